// ----- hw/rtl/button_led_pattern_sequencer_core_defines.svh -----
// Assertion macros shared by the lamp sequencer RTL.
`ifndef BUTTON_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH
`define BUTTON_LED_PATTERN_SEQUENCER_CORE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BLPS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a consequence on the same clock edge.
`define BLPS_ASSERT_IMPL(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/blps_pkg.sv -----
// Shared types, state codes, masks and pattern tables of the lamp sequencer.
`default_nettype none
package blps_pkg;

   localparam int LAMP_W = 11;
   localparam int HIST_W = 8;
   localparam int CODE_W = 4;

   localparam logic [LAMP_W-1:0] LAMP_ALL_OFF = 11'h7FF;
   localparam logic [LAMP_W-1:0] LAMP_ALL_ON  = 11'h000;
   localparam logic [HIST_W-1:0] WAKE_HISTORY = 8'b1111_0000;
   localparam logic [HIST_W-1:0] REL_MASK     = 8'b0000_1111;
   localparam logic [HIST_W-1:0] PAIR_MASK    = 8'h03;
   // button mask 0x111 seen through the 8-bit history is 0x11
   localparam logic [HIST_W-1:0] MODE_MASK    = 8'h11;

   localparam logic [CODE_W-1:0] ST_OFF        = 4'd0;
   localparam logic [CODE_W-1:0] ST_WAIT_REL   = 4'd1;
   localparam logic [CODE_W-1:0] ST_WAIT_PRESS = 4'd2;
   localparam logic [CODE_W-1:0] ST_WAIT_REL2  = 4'd3;
   localparam logic [CODE_W-1:0] ST_WAIT_FREE  = 4'd4;
   localparam logic [CODE_W-1:0] ST_CHASE_SYNC = 4'd5;
   localparam logic [CODE_W-1:0] ST_CHASE_RUN  = 4'd6;
   localparam logic [CODE_W-1:0] ST_WAVE_SYNC  = 4'd7;
   localparam logic [CODE_W-1:0] ST_WAVE_RUN   = 4'd8;
   localparam logic [CODE_W-1:0] ST_RAND_SYNC  = 4'd9;
   localparam logic [CODE_W-1:0] ST_RAND_RUN   = 4'd10;

   localparam logic [1:0] MODE_CHASE  = 2'd0;
   localparam logic [1:0] MODE_WAVE   = 2'd1;
   localparam logic [1:0] MODE_RANDOM = 2'd2;

   localparam logic [CODE_W-1:0] CHASE_LAST = 4'd10;
   localparam logic [CODE_W-1:0] WAVE_LAST  = 4'd6;

   typedef struct packed {
      logic [HIST_W-1:0] hist;
      logic [CODE_W-1:0] code;
      logic [CODE_W-1:0] idx;
      logic              long_seen;
      logic [LAMP_W-1:0] lamp;
   } blps_state_type;

   typedef struct packed {
      logic [LAMP_W-1:0] lamp;
      logic [CODE_W-1:0] idx;
   } blps_pattern_type;

   function automatic logic [LAMP_W-1:0] wave_lit(input logic [2:0] pos);
      logic [LAMP_W-1:0] lit;
      case (pos)
         3'd0:    lit = 11'b000_0001_1000;
         3'd1:    lit = 11'b000_0010_0111;
         3'd2:    lit = 11'b100_0100_0000;
         3'd3:    lit = 11'b010_1000_0000;
         3'd4:    lit = 11'b001_0000_0000;
         default: lit = 11'b000_0000_0000;
      endcase
      return lit;
   endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/blps_pattern.sv -----
// Lamp pattern generator for chase, wave and random modes.
`default_nettype none
module blps_pattern (
   input  wire logic [1:0]                   mode,
   input  wire logic [blps_pkg::CODE_W-1:0]  idx,
   input  wire logic [blps_pkg::LAMP_W-1:0]  random_word,
   input  wire logic [blps_pkg::LAMP_W-1:0]  lamp_cur,
   output blps_pkg::blps_pattern_type        pat
);
   import blps_pkg::*;

   always_comb begin
      pat.lamp = lamp_cur;
      pat.idx  = idx;
      case (mode)
         MODE_CHASE: begin
            if (idx <= CHASE_LAST) begin
               pat.lamp = ~(LAMP_W'(1) << idx);
            end else begin
               pat.lamp = LAMP_ALL_OFF;
            end
            pat.idx = (idx >= CHASE_LAST) ? '0 : idx + 1'b1;
         end
         MODE_WAVE: begin
            if (idx <= WAVE_LAST) begin
               pat.lamp = ~wave_lit(idx[2:0]);
            end
            pat.idx = (idx >= WAVE_LAST) ? '0 : idx + 1'b1;
         end
         default: begin
            pat.lamp = random_word;
         end
      endcase
   end

endmodule
`default_nettype wire

// ----- hw/rtl/blps_step.sv -----
// Next-state logic for one tick: history shift, mode steps and chained button waits.
`default_nettype none
module blps_step (
   input  wire logic                         button_level,
   input  wire logic [blps_pkg::LAMP_W-1:0]  random_word,
   input  wire blps_pkg::blps_state_type     cur,
   output blps_pkg::blps_state_type          nxt
);
   import blps_pkg::*;

   logic [HIST_W-1:0] shifted;
   logic [CODE_W-1:0] code_ofs;
   logic [1:0]        mode;
   blps_pattern_type  pat;
   blps_state_type    s;

   assign shifted  = {cur.hist[HIST_W-2:0], button_level};
   assign code_ofs = cur.code - ST_CHASE_SYNC;
   assign mode     = code_ofs[2:1];

   blps_pattern u_pattern (
      .mode        (mode),
      .idx         (cur.idx),
      .random_word (random_word),
      .lamp_cur    (cur.lamp),
      .pat         (pat)
   );

   always_comb begin
      s = cur;
      case (cur.code) inside
         ST_OFF: begin
            if (!button_level) begin
               s.lamp = LAMP_ALL_ON;
               s.hist = WAKE_HISTORY;
               s.code = ST_WAIT_REL;
            end
         end
         ST_CHASE_SYNC, ST_WAVE_SYNC, ST_RAND_SYNC: begin
            s.hist = shifted;
            s.lamp = pat.lamp;
            s.idx  = pat.idx;
            s.code = cur.code + 1'b1;
         end
         ST_CHASE_RUN, ST_WAVE_RUN, ST_RAND_RUN: begin
            s.hist = shifted;
            if ((shifted & MODE_MASK) == '0) begin
               s.code = ST_WAIT_FREE;
               s.idx  = {2'b00, mode} + 1'b1;
            end else begin
               s.lamp = pat.lamp;
               s.idx  = pat.idx;
            end
         end
         ST_WAIT_REL, ST_WAIT_PRESS, ST_WAIT_REL2, ST_WAIT_FREE: begin
            s.hist = shifted;
         end
         default: begin
            s.lamp = LAMP_ALL_OFF;
            s.code = ST_OFF;
         end
      endcase

      // chain the waits that the same history already satisfies
      if (s.code == ST_WAIT_REL && (s.hist & REL_MASK) == REL_MASK) begin
         s.code = ST_WAIT_PRESS;
      end
      if (s.code == ST_WAIT_PRESS && (s.hist & PAIR_MASK) == '0) begin
         s.code      = ST_WAIT_REL2;
         s.long_seen = 1'b0;
      end
      if (s.code == ST_WAIT_REL2) begin
         if (s.hist == '0) begin
            s.long_seen = 1'b1;
         end
         if ((s.hist & PAIR_MASK) == PAIR_MASK) begin
            if (s.long_seen) begin
               s.code = ST_WAIT_FREE;
               s.idx  = '0;
            end else begin
               s.code = ST_OFF;
               s.lamp = LAMP_ALL_OFF;
            end
         end
      end
      if (s.code == ST_WAIT_FREE && (s.hist & MODE_MASK) == MODE_MASK) begin
         case (s.idx)
            {2'b00, MODE_CHASE}:  s.code = ST_CHASE_SYNC;
            {2'b00, MODE_WAVE}:   s.code = ST_WAVE_SYNC;
            {2'b00, MODE_RANDOM}: s.code = ST_RAND_SYNC;
            default: begin
               s.code = ST_OFF;
               s.lamp = LAMP_ALL_OFF;
            end
         endcase
         s.idx = '0;
      end
      nxt = s;
   end

endmodule
`default_nettype wire

// ----- hw/rtl/button_led_pattern_sequencer_core.sv -----
// Top level of the button-driven eleven-lamp pattern sequencer.
// Usage:
//   The req channel carries one transaction per 0.1 s tick: the sampled button level
//   (1 released, 0 pressed) and an 11-bit random pattern word. Every req transaction
//   yields exactly one rsp transaction with the active-low lamp drive bits, the
//   sequencer step code (0 means off) and a sampling flag.
//   Path: a transaction is captured in the input register; when the rsp side is free,
//   the sequencer state and the result register then update together and rsp_valid
//   rises.
//   Throughput: one transaction per clock while rsp_ready is high; next-state logic is
//   a single short pass between the input register and the state/result registers.
//   Stall: while rsp_ready is low the result register holds its transaction and the
//   input register can still take one more transaction; req_ready drops only when
//   both are full.
//   Reset: synchronous, active high; the sequencer goes off with all lamps dark, the
//   press history and mode index cleared, and both channels empty.
`default_nettype none
`include "button_led_pattern_sequencer_core_defines.svh"
module button_led_pattern_sequencer_core (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic                         req_button_level,
   input  wire logic [blps_pkg::LAMP_W-1:0]  req_random_word,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [blps_pkg::LAMP_W-1:0]       rsp_lamp_drive_n,
   output logic [blps_pkg::CODE_W-1:0]       rsp_sequence_step,
   output logic                              rsp_sampling_on
);
   import blps_pkg::*;

   logic              in_valid_ff, in_valid_in;
   logic              in_level_ff;
   logic [LAMP_W-1:0] in_rnd_ff;
   blps_state_type    state_ff, state_in;
   logic              out_valid_ff, out_valid_in;
   logic              advance;
   logic              req_take;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_take  = req_valid && req_ready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   blps_step u_step (
      .button_level (in_level_ff),
      .random_word  (in_rnd_ff),
      .cur          (state_ff),
      .nxt          (state_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_level_ff <= req_button_level;
         in_rnd_ff   <= req_random_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.hist      <= '0;
         state_ff.code      <= ST_OFF;
         state_ff.idx       <= '0;
         state_ff.long_seen <= 1'b0;
         state_ff.lamp      <= LAMP_ALL_OFF;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_lamp_drive_n  = state_ff.lamp;
   assign rsp_sequence_step = state_ff.code;
   assign rsp_sampling_on   = (state_ff.code != ST_OFF);

   `BLPS_ASSERT(a_code_range, clock, reset, state_ff.code <= ST_RAND_RUN, "step code out of range")
   `BLPS_ASSERT_IMPL(a_off_dark, clock, reset, state_ff.code == ST_OFF,
                     state_ff.lamp == LAMP_ALL_OFF, "lamps lit while off")
   `BLPS_ASSERT_IMPL(a_state_hold, clock, reset, !advance,
                     ##1 $stable(state_ff), "state moved without a transaction")

endmodule
`default_nettype wire

// ----- tb/sv/button_led_pattern_sequencer_core_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the button-driven eleven-lamp pattern sequencer core.
module button_led_pattern_sequencer_core_tb;
   import blps_pkg::*;

   localparam int unsigned RANDOM_TICKS = 2000;
   localparam int unsigned DRAIN_EVERY  = 450;
   localparam int unsigned MAX_WAIT     = 17;
   localparam int unsigned LONG_HOLD    = 120;
   localparam int unsigned IDLE_LIMIT   = 2000;
   localparam int unsigned TAIL_CYCLES  = 8;
   localparam int unsigned MAX_PRINTS   = 40;

   localparam logic [6:0][LAMP_W-1:0] WAVE_ON = {
      11'h000, 11'h000, 11'h100, 11'h280, 11'h440, 11'h027, 11'h018
   };

   typedef struct {
      logic              level;
      logic [LAMP_W-1:0] word;
      bit                drain;
   } button_tick_type;

   typedef struct packed {
      logic [LAMP_W-1:0] lamp;
      logic [CODE_W-1:0] step;
      logic              on;
   } lamp_result_type;

   logic              clock            = 1'b0;
   logic              reset            = 1'b1;
   logic              req_valid        = 1'b0;
   logic              req_ready;
   logic              req_button_level = 1'b1;
   logic [LAMP_W-1:0] req_random_word  = '0;
   logic              rsp_valid;
   logic              rsp_ready        = 1'b0;
   logic [LAMP_W-1:0] rsp_lamp_drive_n;
   logic [CODE_W-1:0] rsp_sequence_step;
   logic              rsp_sampling_on;

   logic [HIST_W-1:0] press_hist = '0;
   logic [CODE_W-1:0] seq_code   = ST_OFF;
   logic [CODE_W-1:0] pat_idx    = '0;
   logic              held_long  = 1'b0;
   logic [LAMP_W-1:0] lamp_reg   = LAMP_ALL_OFF;

   button_tick_type tick_queue[$];
   lamp_result_type lamp_expect[$];

   int unsigned req_count   = 0;
   int unsigned rsp_count   = 0;
   int unsigned error_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned tx_wait     = 0;
   int unsigned rx_wait     = 0;
   bit          tx_calm     = 1'b0;
   bit          rx_calm     = 1'b0;

   button_led_pattern_sequencer_core DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_button_level  (req_button_level),
      .req_random_word   (req_random_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_lamp_drive_n  (rsp_lamp_drive_n),
      .rsp_sequence_step (rsp_sequence_step),
      .rsp_sampling_on   (rsp_sampling_on)
   );

   always #6 clock = ~clock;

   task automatic report_mismatch(input string what);
      if (error_count < MAX_PRINTS)
         $display("%0t: result %0d: %s", $time, rsp_count, what);
      error_count++;
   endtask

   function automatic logic [1:0] mode_of(input logic [CODE_W-1:0] code);
      case (code)
         ST_CHASE_SYNC, ST_CHASE_RUN: return MODE_CHASE;
         ST_WAVE_SYNC, ST_WAVE_RUN:   return MODE_WAVE;
         default:                     return MODE_RANDOM;
      endcase
   endfunction

   task automatic go_dark();
      lamp_reg = LAMP_ALL_OFF;
      seq_code = ST_OFF;
   endtask

   task automatic show_next(input logic [1:0] mode, input logic [LAMP_W-1:0] word);
      if (mode == MODE_CHASE) begin
         lamp_reg = (pat_idx <= CHASE_LAST) ? ~(11'd1 << pat_idx) : LAMP_ALL_OFF;
         pat_idx = (pat_idx >= CHASE_LAST) ? '0 : pat_idx + 4'd1;
      end else if (mode == MODE_WAVE) begin
         if (pat_idx <= WAVE_LAST)
            lamp_reg = ~WAVE_ON[pat_idx];
         pat_idx = (pat_idx >= WAVE_LAST) ? '0 : pat_idx + 4'd1;
      end else begin
         lamp_reg = word;
      end
   endtask

   task automatic settle_waits();
      bit done;
      int n;
      done = 1'b0;
      for (n = 0; n < 5 && !done; n++) begin
         case (seq_code)
            ST_WAIT_REL: begin
               if ((press_hist & REL_MASK) != REL_MASK) done = 1'b1;
               else seq_code = ST_WAIT_PRESS;
            end
            ST_WAIT_PRESS: begin
               if ((press_hist & PAIR_MASK) != '0) done = 1'b1;
               else begin
                  seq_code = ST_WAIT_REL2;
                  held_long = 1'b0;
               end
            end
            ST_WAIT_REL2: begin
               if (press_hist == '0) held_long = 1'b1;
               if ((press_hist & PAIR_MASK) != PAIR_MASK) done = 1'b1;
               else if (held_long) begin
                  seq_code = ST_WAIT_FREE;
                  pat_idx = '0;
               end else begin
                  go_dark();
                  done = 1'b1;
               end
            end
            ST_WAIT_FREE: begin
               if ((press_hist & MODE_MASK) == MODE_MASK) begin
                  if (pat_idx == MODE_CHASE) seq_code = ST_CHASE_SYNC;
                  else if (pat_idx == MODE_WAVE) seq_code = ST_WAVE_SYNC;
                  else if (pat_idx == MODE_RANDOM) seq_code = ST_RAND_SYNC;
                  else go_dark();
                  pat_idx = '0;
               end
               done = 1'b1;
            end
            default: done = 1'b1;
         endcase
      end
   endtask

   task automatic predict_tick(input logic level, input logic [LAMP_W-1:0] word);
      logic [CODE_W-1:0] st;
      lamp_result_type r;
      st = seq_code;
      if (st == ST_OFF) begin
         if (!level) begin
            lamp_reg = LAMP_ALL_ON;
            press_hist = WAKE_HISTORY;
            seq_code = ST_WAIT_REL;
            settle_waits();
         end
      end else begin
         press_hist = {press_hist[HIST_W-2:0], level};
         case (st)
            ST_CHASE_SYNC, ST_WAVE_SYNC, ST_RAND_SYNC: begin
               show_next(mode_of(st), word);
               seq_code = st + 4'd1;
            end
            ST_CHASE_RUN, ST_WAVE_RUN, ST_RAND_RUN: begin
               if ((press_hist & MODE_MASK) == '0) begin
                  seq_code = ST_WAIT_FREE;
                  pat_idx = {2'b00, mode_of(st)} + 4'd1;
                  settle_waits();
               end else begin
                  show_next(mode_of(st), word);
               end
            end
            ST_WAIT_REL, ST_WAIT_PRESS, ST_WAIT_REL2, ST_WAIT_FREE: settle_waits();
            default: go_dark();
         endcase
      end
      r.lamp = lamp_reg;
      r.step = seq_code;
      r.on   = (seq_code != ST_OFF);
      lamp_expect.push_back(r);
   endtask

   task automatic add_run(input logic level, input int unsigned len, input bit drain);
      button_tick_type t;
      int unsigned i;
      for (i = 0; i < len; i++) begin
         case ($urandom_range(0, 7))
            0:       t.word = LAMP_ALL_OFF;
            1:       t.word = LAMP_ALL_ON;
            default: t.word = LAMP_W'($urandom_range(0, 2047));
         endcase
         t.level = level;
         t.drain = drain && (i == 0);
         tick_queue.push_back(t);
      end
   endtask

   always @(posedge clock) begin : drive_req
      bit nvalid;
      int unsigned nwait;
      int unsigned nreq;
      button_tick_type item;
      if (reset) begin
         req_valid <= 1'b0;
         tx_wait <= 0;
      end else begin
         nvalid = req_valid;
         nwait = tx_wait;
         nreq = req_count;
         if (req_valid && req_ready) begin
            predict_tick(req_button_level, req_random_word);
            nreq++;
            nvalid = 1'b0;
            if ($urandom_range(0, 49) == 0) tx_calm = !tx_calm;
            nwait = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end
         if (!nvalid) begin
            if (nwait > 0) begin
               nwait--;
            end else if (tick_queue.size() > 0 &&
                         (!tick_queue[0].drain || nreq == rsp_count)) begin
               item = tick_queue.pop_front();
               req_button_level <= item.level;
               req_random_word <= item.word;
               nvalid = 1'b1;
            end
         end
         req_valid <= nvalid;
         tx_wait <= nwait;
         req_count <= nreq;
      end
   end

   always @(posedge clock) begin : watch_rsp
      int unsigned nwait;
      int unsigned nrsp;
      lamp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_wait <= 0;
      end else begin
         nwait = rx_wait;
         nrsp = rsp_count;
         if (rsp_valid && rsp_ready) begin
            nrsp++;
            if (lamp_expect.size() == 0) begin
               report_mismatch("transaction with no tick pending");
            end else begin
               want = lamp_expect.pop_front();
               if (rsp_lamp_drive_n !== want.lamp)
                  report_mismatch($sformatf("lamp_drive_n 0x%0h, expected 0x%0h",
                                            rsp_lamp_drive_n, want.lamp));
               if (rsp_sequence_step !== want.step)
                  report_mismatch($sformatf("sequence_step %0d, expected %0d",
                                            rsp_sequence_step, want.step));
               if (rsp_sampling_on !== want.on)
                  report_mismatch($sformatf("sampling_on %0b, expected %0b",
                                            rsp_sampling_on, want.on));
            end
            if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
            nwait = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
            // hold off long enough to back the block up into its input
            if (nrsp == 300 || nrsp == 1300) nwait = LONG_HOLD;
         end
         if (nwait > 0) begin
            rsp_ready <= 1'b0;
            nwait--;
         end else begin
            rsp_ready <= 1'b1;
         end
         rx_wait <= nwait;
         rsp_count <= nrsp;
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", idle_cycles);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : run_ticks
      int unsigned n;
      int unsigned len;
      int unsigned drain_at;
      bit seg_level;
      bit drain;
      // off with button released, wake, short press back to off
      add_run(1'b1, 1, 1'b0);
      add_run(1'b0, 1, 1'b0);
      add_run(1'b1, 4, 1'b0);
      add_run(1'b0, 2, 1'b0);
      add_run(1'b1, 2, 1'b0);
      // wake again, long press, release into the chase
      add_run(1'b0, 1, 1'b0);
      add_run(1'b1, 4, 1'b0);
      add_run(1'b0, 8, 1'b0);
      add_run(1'b1, 5, 1'b0);
      n = 0;
      drain_at = 0;
      seg_level = 1'b1;
      while (n < RANDOM_TICKS) begin
         if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(1, 8);
            repeat (len) add_run(1'($urandom_range(0, 1)), 1, 1'b0);
         end else begin
            seg_level = !seg_level;
            if (!seg_level && $urandom_range(0, 2) == 0) len = $urandom_range(8, 14);
            else if (!seg_level) len = $urandom_range(1, 4);
            else len = $urandom_range(1, 12);
            drain = (n >= drain_at);
            if (drain) drain_at += DRAIN_EVERY;
            add_run(seg_level, len, drain);
         end
         n += len;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      while (tick_queue.size() != 0 || req_valid || req_count != rsp_count)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (lamp_expect.size() != 0)
         report_mismatch($sformatf("%0d expected transactions never arrived",
                                   lamp_expect.size()));
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
